FILE: rtl/core/swmm_pkg.sv
// Shared constants and controller/datapath interface types for the window min/max block.
package swmm_pkg;

  // Window geometry
  localparam int WINDOW   = 64;
  localparam int ADDR_W   = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SAMPLE_W = 10;

  // Start value of the running minimum (all ones over the sample width)
  localparam logic [SAMPLE_W-1:0] MIN_START = {SAMPLE_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr;      // store the accepted sample and start a new scan
    logic scan;    // scan in progress
    logic ld_out;  // load the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic done;    // scan finished, min and max complete
  } sts_t;

endpackage

FILE: rtl/core/swmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/swmm_dp.sv
// Datapath: sample ring, entry valid bits, scan counter, min/max accumulators, result register.
module swmm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  swmm_pkg::cmd_t                       cmd,
  input  logic [swmm_pkg::SAMPLE_W-1:0]        sample,
  output swmm_pkg::sts_t                       sts,
  output logic [swmm_pkg::SAMPLE_W-1:0]        window_min,
  output logic [swmm_pkg::SAMPLE_W-1:0]        window_max
);
  import swmm_pkg::*;

  logic [ADDR_W-1:0]   wpos_r, wpos_nxt;
  logic [WINDOW-1:0]   vld_r, vld_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic                ent_ok_r, ent_ok_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic [SAMPLE_W-1:0] min_r, max_r;
  logic                rd_en;
  logic [SAMPLE_W-1:0] ram_q;
  logic [SAMPLE_W-1:0] ent;

  // Read one entry per cycle while the scan runs
  assign rd_en = cmd.scan && (cnt_r < CNT_W'(WINDOW));

  swmm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wpos_r),
    .wdata (sample),
    .re    (rd_en),
    .raddr (cnt_r[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  // Entries never written read as zero
  assign ent = ent_ok_r ? ram_q : '0;

  // Next-state logic for write pointer, valid bits, scan and accumulators
  always_comb begin
    wpos_nxt   = wpos_r;
    vld_nxt    = vld_r;
    cnt_nxt    = cnt_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    pend_nxt   = rd_en;
    ent_ok_nxt = vld_r[cnt_r[ADDR_W-1:0]];
    if (cmd.wr) begin
      vld_nxt[wpos_r] = 1'b1;
      wpos_nxt = (wpos_r == ADDR_W'(WINDOW - 1)) ? '0 : wpos_r + 1'b1;
      cnt_nxt  = '0;
      lo_nxt   = MIN_START;
      hi_nxt   = '0;
    end else begin
      if (rd_en) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (pend_r) begin
        if (ent < lo_r) lo_nxt = ent;
        if (ent > hi_r) hi_nxt = ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r   <= '0;
      vld_r    <= '0;
      cnt_r    <= CNT_W'(WINDOW);
      pend_r   <= 1'b0;
      ent_ok_r <= 1'b0;
      lo_r     <= '0;
      hi_r     <= '0;
    end else begin
      wpos_r   <= wpos_nxt;
      vld_r    <= vld_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      ent_ok_r <= ent_ok_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      min_r <= lo_r;
      max_r <= hi_r;
    end
  end

  assign sts.done   = (cnt_r == CNT_W'(WINDOW)) && !pend_r;
  assign window_min = min_r;
  assign window_max = max_r;

  // Completed scan never leaves min above max
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (lo_r <= hi_r))
    else $error("scan result has min above max");

  // A store always marks its entry valid
  a_store_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> vld_r[$past(wpos_r)])
    else $error("stored entry not marked valid");

endmodule

FILE: rtl/core/swmm_ctrl.sv
// Controller: sequences accept, scan and result hand-off; owns the output valid flag.
module swmm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  swmm_pkg::sts_t sts,
  output swmm_pkg::cmd_t cmd
);
  import swmm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   out_free;

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // State transitions and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.wr     = 1'b0;
    cmd.scan   = 1'b0;
    cmd.ld_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.wr    = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.done) begin
          if (out_free) begin
            cmd.ld_out = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared on transfer
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.ld_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;

  // An accepted sample always starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SCAN))
    else $error("accepted sample did not start a scan");

  // A finished result waits while the output register is stalled
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_vld_r && !out_tready) |=> (state_r == S_HOLD))
    else $error("result left hold while output stalled");

  // Result load only after a complete scan
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> sts.done)
    else $error("result loaded before scan finished");

endmodule

FILE: rtl/core/sliding_window_min_max.sv
// An input transfer starts a scan that reads one ring entry per cycle through the single
// read port of the sample RAM into the min/max accumulators; the result is then loaded
// into the output register once it is free; no new sample is taken before that load.
// A new sample is taken while the previous result still waits in the output register.
// Reset (rst_n low, synchronous) clears the entry valid bits and write position, so the
// ring reads as all zeros; no clearing pass is needed and the block is ready at once.
module sliding_window_min_max (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] sample, [15:10] ignored
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [9:0] window_min, [19:10] window_max, [23:20] zero
);
  import swmm_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [SAMPLE_W-1:0] window_min;
  logic [SAMPLE_W-1:0] window_max;

  swmm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  swmm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample     (in_tdata[SAMPLE_W-1:0]),
    .sts        (sts),
    .window_min (window_min),
    .window_max (window_max)
  );

  assign out_tdata = {4'b0, window_max, window_min};

endmodule

FILE: sim/window_extrema_checker.sv
// Checker for the sliding-window min/max block: predicts window extremes and compares results.
`timescale 1ns / 100ps

module window_extrema_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,     // [9:0] sample, [15:10] ignored
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,    // [9:0] window_min, [19:10] window_max, [23:20] zero
  output int unsigned fail_count,
  output int unsigned results_owed
);
  import swmm_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
  } extrema_t;

  // Own copy of the ring and its write pointer
  logic [SAMPLE_W-1:0] ring_copy [WINDOW];
  logic [ADDR_W-1:0]   next_slot;

  // Extremes still owed by the block, oldest first
  extrema_t extrema_due [$];

  // Store one sample, then scan the whole window for its extremes
  function automatic extrema_t update_ring_extrema(input logic [SAMPLE_W-1:0] sample);
    extrema_t r;
    ring_copy[next_slot] = sample;
    next_slot = (next_slot == ADDR_W'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
    r.lo = MIN_START;
    r.hi = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (ring_copy[i] > r.hi) r.hi = ring_copy[i];
      if (ring_copy[i] < r.lo) r.lo = ring_copy[i];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    extrema_t want;
    logic [SAMPLE_W-1:0] got_lo;
    logic [SAMPLE_W-1:0] got_hi;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) ring_copy[i] = '0;
      next_slot = '0;
      extrema_due.delete();
      fail_count = 0;
    end else begin
      got_lo = out_tdata[SAMPLE_W-1:0];
      got_hi = out_tdata[2*SAMPLE_W-1:SAMPLE_W];
      // Result transfer: compare against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (extrema_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got min %0d max %0d",
                   $time, got_lo, got_hi);
          fail_count++;
        end else begin
          want = extrema_due.pop_front();
          if (got_lo !== want.lo) begin
            $display("%0t: window_min mismatch, expected %0d, got %0d",
                     $time, want.lo, got_lo);
            fail_count++;
          end
          if (got_hi !== want.hi) begin
            $display("%0t: window_max mismatch, expected %0d, got %0d",
                     $time, want.hi, got_hi);
            fail_count++;
          end
        end
      end
      // Sample transfer: only the low sample bits reach the ring
      if (in_tvalid && in_tready)
        extrema_due.push_back(update_ring_extrema(in_tdata[SAMPLE_W-1:0]));
    end
    results_owed = extrema_due.size();
  end

endmodule

FILE: sim/tb.sv
// Testbench top: drives samples and result back-pressure, gives the final verdict.
`timescale 1ns / 100ps

module tb;
  import swmm_pkg::*;

  localparam int RANDOM_PER_PHASE = 134;
  localparam int RUN_LEN          = 32;

  // Random sample shapes
  localparam int MODE_SPREAD = 0;
  localparam int MODE_BAND   = 1;
  localparam int MODE_RAMP   = 2;
  localparam int MODE_EDGE   = 3;

  localparam logic [15:0] EDGE_VALUES [4] = '{16'd0, 16'd1, 16'd1022, 16'd1023};

  // Extremes, alternating bit patterns, and junk above the sample bits
  localparam logic [15:0] DIRECTED [14] = '{
    16'd0,     16'd1023, 16'd512,   16'hFFFF, 16'hFC00, 16'h0155, 16'h02AA,
    16'd1,     16'd1022, 16'hAAAA,  16'h5555, 16'h8001, 16'h7FFE, 16'd1023
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;     // [9:0] sample, [15:10] ignored
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [9:0] window_min, [19:10] window_max, [23:20] zero

  int unsigned fail_count;
  int unsigned results_owed;
  int          send_idle_pct = 25;
  int          recv_idle_pct = 78;

  sliding_window_min_max dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  window_extrema_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One sample transfer, with random idle cycles in front; called at a falling edge
  task automatic push_sample(input logic [15:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender back until the block has delivered everything
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] word;
    int          mode;
    int          level;
    int          step;
    mode  = MODE_SPREAD;
    level = 0;
    step  = 1;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed samples while the window still holds reset zeros
    foreach (DIRECTED[i]) push_sample(DIRECTED[i]);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Runs of one shape, so old extremes age out of the window
        if (n % RUN_LEN == 0) begin
          mode  = $urandom_range(3);
          level = $urandom_range(1008);
          step  = int'($urandom_range(40)) - 20;
        end
        case (mode)
          MODE_SPREAD: word = 16'($urandom_range(1023));
          MODE_BAND: begin
            level = level + int'($urandom_range(8)) - 4;
            if (level < 0) level = 0;
            if (level > 1008) level = 1008;
            word = 16'(level + int'($urandom_range(15)));
          end
          MODE_RAMP: begin
            level = (level + step + 1024) % 1024;
            word  = 16'(level);
          end
          default: word = EDGE_VALUES[$urandom_range(3)];
        endcase
        // Occasional junk above the sample bits, which the block must drop
        if ($urandom_range(15) == 0) word[15:SAMPLE_W] = 6'($urandom_range(63));
        push_sample(word);
      end
      drain_results();
    end

    // Tail: everything delivered, then allow for any late stray result
    recv_idle_pct = 0;
    while (results_owed != 0) @(negedge clk);
    repeat (WINDOW + 10) @(negedge clk);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/swmm_pkg.sv
rtl/core/swmm_ram.sv
rtl/core/swmm_dp.sv
rtl/core/swmm_ctrl.sv
rtl/core/sliding_window_min_max.sv
sim/window_extrema_checker.sv
sim/tb.sv
